// ===== sv/sirs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirs_pkg
// Shared widths, types and codes of the sorted increment ratio sum unit.
// ---------------------------------------------------------------------------
package sirs_pkg;

    localparam int SIRS_DEPTH = 256;
    localparam int TIME_W     = 32;
    localparam int PRICE_W    = 32;
    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 9;
    localparam int MODE_W     = 2;
    // |dp| fits 32 bits, so dp^2 << 16 and |dp| << 32 both fit 80 bits
    localparam int NUM_W      = 80;
    localparam int ROOT_IN_W  = 56;
    localparam int ROOT_W     = 28;

    typedef logic [TIME_W-1:0]         time_t;
    typedef logic signed [PRICE_W-1:0] price_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [MODE_W-1:0]         mode_t;

    localparam mode_t MODE_DRIFT    = 2'd0;
    localparam mode_t MODE_VARIANCE = 2'd1;
    localparam mode_t MODE_ROOT     = 2'd2;
    localparam mode_t MODE_COUNT    = 2'd3;

    localparam count_t COUNT_MAX = '1;

    // Control broadcast to every sort cell
    typedef struct packed {
        logic   insert;
        logic   shift;
        time_t  x_time;
        price_t x_price;
    } cell_ctl_t;

endpackage

// ===== sv/sirs_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirs_if
// Channel interfaces: configuration, sample and result beats.
// ---------------------------------------------------------------------------
interface sirs_cfg_if;
    import sirs_pkg::*;
    logic  valid;
    logic  ready;
    mode_t mode;
    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

interface sirs_sample_if;
    import sirs_pkg::*;
    logic   valid;
    logic   ready;
    time_t  timestamp;
    price_t price;
    logic   last;
    modport source (output valid, output timestamp, output price, output last, input ready);
    modport sink (input valid, input timestamp, input price, input last, output ready);
endinterface

interface sirs_result_if;
    import sirs_pkg::*;
    logic   valid;
    logic   ready;
    value_t result_value;
    count_t distinct_count;
    logic   overflow;
    logic   saturated;
    modport source (output valid, output result_value, output distinct_count,
                    output overflow, output saturated, input ready);
    modport sink (input valid, input result_value, input distinct_count,
                  input overflow, input saturated, output ready);
endinterface

// ===== sv/sirs_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirs_cell
// One slot of the insertion sorting chain; holds one sample.
// ---------------------------------------------------------------------------
module sirs_cell (
    input  logic                clk,
    input  sirs_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  logic                left_gt,
    input  sirs_pkg::time_t     left_time,
    input  sirs_pkg::price_t    left_price,
    input  sirs_pkg::time_t     right_time,
    input  sirs_pkg::price_t    right_price,
    output logic                gt,
    output sirs_pkg::time_t     time_q,
    output sirs_pkg::price_t    price_q
);
    import sirs_pkg::*;

    time_t  time_reg;
    price_t price_reg;

    // Empty slots rank above everything; equal times keep arrival order
    assign gt      = !occupied || (time_reg > ctl.x_time);
    assign time_q  = time_reg;
    assign price_q = price_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.insert && gt)
        begin
            if (left_gt)
            begin
                time_reg  <= left_time;
                price_reg <= left_price;
            end
            else
            begin
                time_reg  <= ctl.x_time;
                price_reg <= ctl.x_price;
            end
        end
        else if (ctl.shift)
        begin
            time_reg  <= right_time;
            price_reg <= right_price;
        end
    end

endmodule

// ===== sv/sirs_sqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirs_sqrt
// Iterative integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module sirs_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sirs_pkg::ROOT_IN_W-1:0] x,
    output logic                          done,
    output logic [sirs_pkg::ROOT_W-1:0]    root
);
    import sirs_pkg::*;

    logic [ROOT_IN_W-1:0] x_reg;
    logic [ROOT_IN_W-1:0] res_reg;
    logic [ROOT_IN_W-1:0] bit_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [ROOT_IN_W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign done  = done_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
                busy_reg <= 1'b1;
            else if (bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            res_reg <= '0;
            bit_reg <= {2'b01, {(ROOT_IN_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if ({1'b0, x_reg} >= trial)
            begin
                x_reg   <= x_reg - trial[ROOT_IN_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

// ===== sv/sirs_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirs_div
// Restoring divider, wide numerator by 32-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module sirs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sirs_pkg::NUM_W-1:0] num,
    input  logic [31:0]               den,
    output logic                      done,
    output logic [sirs_pkg::NUM_W-1:0] quot
);
    import sirs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] nq_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic             fits;

    assign trial = {rem_reg, nq_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = nq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(NUM_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            // shift quotient bits in behind the numerator
            nq_reg  <= {nq_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        end
    end

endmodule

// ===== sv/sorted_increment_ratio_sum_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_increment_ratio_sum_unit
// Sorts a group of samples by timestamp and sums per-step price ratios.
// ---------------------------------------------------------------------------
// Usage
//   cfg    : write beat sets the 2-bit mode (drift, variance, root-gap
//            drift, distinct count). Write only while the block is idle.
//   sample : one beat per cycle while loading. Each beat is inserted into a
//            chain of DEPTH sort cells at once, ties after earlier arrivals.
//            Beats beyond DEPTH are dropped and flag overflow.
//   result : one beat per group, issued after the beat marked last.
// Draining
//   After last the chain drains one sample per step through cell 0. A
//   pair with no time gap, or any pair in count mode, passes the fetch
//   and pair states only; a contributing pair goes on through start,
//   the bit-serial divider (80 quotient bits) and accumulate, after a
//   multiply in mode 1 or the bit-serial square root (28 bits) in mode 2.
// Reset and stalls
//   Reset empties the group and clears mode to drift; the chain is not
//   cleared. A finished result waits in the output register; the block
//   takes the next group meanwhile and holds its own result until the
//   register is free.
// ---------------------------------------------------------------------------
module sorted_increment_ratio_sum_unit #(
    parameter int DEPTH = sirs_pkg::SIRS_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    sirs_cfg_if.sink     cfg,
    sirs_sample_if.sink  sample,
    sirs_result_if.source result
);
    import sirs_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_PAIR  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_SQRT  = 9'b000010000,
        S_START = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_ACC   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] remain_reg;
    logic              ovf_reg;
    logic              first_reg;
    time_t             prev_t_reg, cur_t_reg;
    price_t            prev_p_reg, cur_p_reg;
    logic [31:0]       dt_reg;
    logic [31:0]       mag_reg;
    logic              neg_reg;
    logic [63:0]       sq_reg;
    value_t            acc_reg;
    logic              sat_reg;
    count_t            count_reg;

    logic              out_valid_reg;
    value_t            out_value_reg;
    count_t            out_count_reg;
    logic              out_ovf_reg;
    logic              out_sat_reg;

    cell_ctl_t         ctl;
    time_t             cell_time  [DEPTH];
    price_t            cell_price [DEPTH];
    logic              cell_gt    [DEPTH];

    logic              in_beat;
    logic              room;
    logic              emit_go;
    logic              pair_done;
    logic [32:0]       dp;
    logic [32:0]       dp_abs;
    logic              sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [31:0]       root_reg;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [31:0]       div_den;
    logic [NUM_W-1:0]  quot;
    value_t            term;
    logic              term_sat;
    logic [64:0]       sum;
    value_t            acc_new;
    logic              acc_sat;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == S_LOAD);
    assign in_beat      = sample.valid && sample.ready;
    assign room         = (fill_reg < FILL_W'(DEPTH));
    assign emit_go      = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    // Broadcast to the sort chain: insert while loading, shift left while draining
    assign ctl.insert  = in_beat && room;
    assign ctl.shift   = (state_reg == S_FETCH);
    assign ctl.x_time  = sample.timestamp;
    assign ctl.x_price = sample.price;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   l_gt;
        time_t  l_time, r_time;
        price_t l_price, r_price;
        if (i == 0)
        begin : g_head
            assign l_gt    = 1'b0;
            assign l_time  = '0;
            assign l_price = '0;
        end
        else
        begin : g_body
            assign l_gt    = cell_gt[i-1];
            assign l_time  = cell_time[i-1];
            assign l_price = cell_price[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign r_time  = '0;
            assign r_price = '0;
        end
        else
        begin : g_mid
            assign r_time  = cell_time[i+1];
            assign r_price = cell_price[i+1];
        end
        sirs_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (FILL_W'(i) < fill_reg),
            .left_gt     (l_gt),
            .left_time   (l_time),
            .left_price  (l_price),
            .right_time  (r_time),
            .right_price (r_price),
            .gt          (cell_gt[i]),
            .time_q      (cell_time[i]),
            .price_q     (cell_price[i])
        );
    end

    // Price step, exact in 33 bits; its magnitude fits 32
    assign dp     = {cur_p_reg[PRICE_W-1], cur_p_reg} - {prev_p_reg[PRICE_W-1], prev_p_reg};
    assign dp_abs = dp[32] ? 33'(-dp) : dp;

    function automatic logic [31:0] dt_next(input time_t t1, input time_t t0);
        dt_next = t1 - t0;
    endfunction

    assign sqrt_start = (state_reg == S_PAIR) && (cur_t_reg > prev_t_reg)
                        && (mode_reg == MODE_ROOT);
    sirs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     ({dt_next(cur_t_reg, prev_t_reg), 24'b0}),
        .done  (sqrt_done),
        .root  (root)
    );

    assign div_start = (state_reg == S_START);
    assign div_num   = (mode_reg == MODE_VARIANCE) ? {sq_reg, 16'b0} : {16'b0, mag_reg, 32'b0};
    assign div_den   = (mode_reg == MODE_ROOT) ? root_reg : dt_reg;
    sirs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // Clip the quotient to int64 with its sign, then add with saturation
    always_comb
    begin
        term_sat = 1'b0;
        if (neg_reg)
        begin
            if ((|quot[NUM_W-1:64]) || (quot[63:0] > 64'h8000_0000_0000_0000))
            begin
                term_sat = 1'b1;
                term     = {1'b1, 63'b0};
            end
            else
                term = value_t'(-quot[63:0]);
        end
        else if (|quot[NUM_W-1:63])
        begin
            term_sat = 1'b1;
            term     = {1'b0, {63{1'b1}}};
        end
        else
            term = value_t'(quot[63:0]);
        sum     = {term[63], term} + {acc_reg[63], acc_reg};
        acc_sat = sum[64] ^ sum[63];
        if (acc_sat)
            acc_new = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            acc_new = sum[63:0];
    end

    // Pair finished: move on to the next sample or to the result
    assign pair_done = ((state_reg == S_PAIR)
                        && (!(cur_t_reg > prev_t_reg) || mode_reg == MODE_COUNT))
                       || (state_reg == S_ACC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
                if (in_beat && sample.last)
                    state_next = S_FETCH;
            S_FETCH:
                if (!first_reg)
                    state_next = S_PAIR;
                else if (remain_reg == FILL_W'(1))
                    state_next = S_EMIT;
            S_PAIR:
                if (pair_done)
                    state_next = (remain_reg == '0) ? S_EMIT : S_FETCH;
                else if (mode_reg == MODE_VARIANCE)
                    state_next = S_MUL;
                else if (mode_reg == MODE_ROOT)
                    state_next = S_SQRT;
                else
                    state_next = S_START;
            S_MUL:
                state_next = S_START;
            S_SQRT:
                if (sqrt_done)
                    state_next = S_START;
            S_START:
                state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_ACC;
            S_ACC:
                state_next = (remain_reg == '0) ? S_EMIT : S_FETCH;
            S_EMIT:
                if (emit_go)
                    state_next = S_LOAD;
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            mode_reg      <= MODE_DRIFT;
            fill_reg      <= '0;
            remain_reg    <= '0;
            ovf_reg       <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
                mode_reg <= cfg.mode;
            if (in_beat)
            begin
                if (room)
                    fill_reg <= fill_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
                if (sample.last)
                begin
                    remain_reg <= room ? fill_reg + 1'b1 : fill_reg;
                    first_reg  <= 1'b1;
                end
            end
            if (state_reg == S_FETCH)
            begin
                remain_reg <= remain_reg - 1'b1;
                first_reg  <= 1'b0;
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
                fill_reg      <= '0;
                ovf_reg       <= 1'b0;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && sample.last)
        begin
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            count_reg <= count_t'(1);
        end
        if (state_reg == S_FETCH)
        begin
            // drained head sample; the first one only seeds the pair
            if (first_reg)
            begin
                prev_t_reg <= cell_time[0];
                prev_p_reg <= cell_price[0];
            end
            else
            begin
                cur_t_reg <= cell_time[0];
                cur_p_reg <= cell_price[0];
            end
        end
        if (state_reg == S_PAIR)
        begin
            dt_reg  <= dt_next(cur_t_reg, prev_t_reg);
            mag_reg <= dp_abs[31:0];
            neg_reg <= dp[32] && (mode_reg != MODE_VARIANCE);
            if ((cur_t_reg > prev_t_reg) && (count_reg != COUNT_MAX))
                count_reg <= count_reg + 1'b1;
        end
        if (state_reg == S_MUL)
            sq_reg <= 64'(mag_reg) * 64'(mag_reg);
        if (sqrt_done)
            root_reg <= 32'(root);
        if (state_reg == S_ACC)
        begin
            acc_reg <= acc_new;
            sat_reg <= sat_reg | term_sat | acc_sat;
        end
        if (pair_done)
        begin
            prev_t_reg <= cur_t_reg;
            prev_p_reg <= cur_p_reg;
        end
        if (emit_go)
        begin
            out_value_reg <= (mode_reg == MODE_COUNT) ? '0 : acc_reg;
            out_count_reg <= count_reg;
            out_ovf_reg   <= ovf_reg;
            out_sat_reg   <= (mode_reg != MODE_COUNT) && sat_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_value   = out_value_reg;
    assign result.distinct_count = out_count_reg;
    assign result.overflow       = out_ovf_reg;
    assign result.saturated      = out_sat_reg;

endmodule

// ===== sim/tb_sorted_increment_ratio_sum_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_increment_ratio_sum_unit
// Self-checking bench: directed table then random groups, all four modes,
// random stalls on both channels, results checked against a local predictor.
// ---------------------------------------------------------------------------
module tb_sorted_increment_ratio_sum_unit;
    import sirs_pkg::*;

    localparam int  DEPTH_TB  = SIRS_DEPTH;
    localparam longint LIMIT  = 3000000;

    typedef struct {
        value_t value;
        count_t count;
        logic   ovf;
        logic   sat;
    } agg_t;

    typedef struct {
        time_t  ts;
        price_t pr;
        logic   last;
        logic   known;  // row carries a typed-in answer
        agg_t   ans;
    } row_t;

    logic clk;
    logic rst_n;

    sirs_cfg_if    cfg_ch ();
    sirs_sample_if smp_ch ();
    sirs_result_if res_ch ();

    sorted_increment_ratio_sum_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (smp_ch),
        .result (res_ch)
    );

    // Predictor state: its own copy of the group store and the mode
    time_t  grp_ts [DEPTH_TB];
    price_t grp_pr [DEPTH_TB];
    int     grp_fill;
    logic   grp_ovf;
    mode_t  cur_mode;

    agg_t   pending_q [$];
    int     errors;
    int     n_results;
    int     n_items;
    longint cycles;
    bit     hold_off;   // long receiver stall requested
    int     mode_use [4];

    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
    endtask

    // Saturate a 130-bit signed value to int64
    function automatic value_t clip64(input logic signed [129:0] v, inout logic sat);
        if (v > 130'sh7FFFFFFFFFFFFFFF)
        begin
            sat = 1'b1;
            return 64'sh7FFFFFFFFFFFFFFF;
        end
        if (v < -130'sh8000000000000000)
        begin
            sat = 1'b1;
            return 64'sh8000000000000000;
        end
        return v[63:0];
    endfunction

    function automatic logic [31:0] root56(input logic [55:0] x);
        logic [31:0] r;
        logic [63:0] sq;
        r = 0;
        for (int b = 27; b >= 0; b--)
        begin
            sq = 64'(r | (32'd1 << b));
            if (sq * sq <= 64'(x))
                r = r | (32'd1 << b);
        end
        return r;
    endfunction

    // Close the group: sort stably by timestamp and sum the mode's terms
    function automatic agg_t close_group();
        agg_t   a;
        int     n, j;
        time_t  t;
        price_t p;
        logic signed [33:0]  dp;
        logic [79:0]         mag, num, q;
        logic [31:0]         dvs;
        logic signed [129:0] term, acc_w;
        logic                sat;
        value_t              acc;
        int                  cnt;
        n = grp_fill;
        for (int i = 1; i < n; i++)
        begin
            t = grp_ts[i];
            p = grp_pr[i];
            j = i;
            while (j > 0 && grp_ts[j-1] > t)
            begin
                grp_ts[j] = grp_ts[j-1];
                grp_pr[j] = grp_pr[j-1];
                j--;
            end
            grp_ts[j] = t;
            grp_pr[j] = p;
        end
        acc = 0;
        sat = 1'b0;
        cnt = 1;
        for (int i = 1; i < n; i++)
        begin
            if (grp_ts[i] <= grp_ts[i-1])
                continue;
            if (cnt < 511)
                cnt++;
            if (cur_mode == MODE_COUNT)
                continue;
            dp  = 34'(grp_pr[i]) - 34'(grp_pr[i-1]);
            mag = 80'(dp < 0 ? -dp : dp);
            dvs = grp_ts[i] - grp_ts[i-1];
            if (cur_mode == MODE_VARIANCE)
                num = (mag * mag) << 16;
            else
                num = mag << 32;
            if (cur_mode == MODE_ROOT)
                dvs = root56(56'(dvs) << 24);
            q = num / 80'(dvs);
            term = 130'(q);
            if (cur_mode != MODE_VARIANCE && dp < 0)
                term = -term;
            term = 130'(clip64(term, sat));
            acc_w = 130'(acc) + term;
            acc = clip64(acc_w, sat);
        end
        a.value = (cur_mode == MODE_COUNT) ? '0 : acc;
        a.count = count_t'(cnt);
        a.ovf   = grp_ovf;
        a.sat   = (cur_mode != MODE_COUNT) && sat;
        grp_fill = 0;
        grp_ovf  = 1'b0;
        return a;
    endfunction

    function automatic void absorb_sample(input time_t ts, input price_t pr, input logic last);
        if (grp_fill < DEPTH_TB)
        begin
            grp_ts[grp_fill] = ts;
            grp_pr[grp_fill] = pr;
            grp_fill++;
        end
        else
            grp_ovf = 1'b1;
        if (last)
        begin
            pending_q = {pending_q, close_group()};
            mode_use[cur_mode]++;
        end
    endfunction

    // Result side: random ready, optional long hold-off, compare each beat
    initial
    begin
        agg_t w;
        int   gap;
        res_ch.ready = 1'b0;
        n_results = 0;
        errors = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_q.size() == 0)
                    report("unexpected result beat", res_ch.result_value, '0);
                else
                begin
                    w = pending_q.pop_front();
                    if (res_ch.result_value !== w.value)
                        report("result_value", res_ch.result_value, w.value);
                    if (res_ch.distinct_count !== w.count)
                        report("distinct_count", 64'(res_ch.distinct_count), 64'(w.count));
                    if (res_ch.overflow !== w.ovf)
                        report("overflow", 64'(res_ch.overflow), 64'(w.ovf));
                    if (res_ch.saturated !== w.sat)
                        report("saturated", 64'(res_ch.saturated), 64'(w.sat));
                end
                n_results++;
            end
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
                continue;
            end
            gap = $urandom_range(0, 99);
            if (gap < 60)
                res_ch.ready <= 1'b1;
            else if (gap < 95)
                res_ch.ready <= 1'b0;
            else
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 300)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Drive one sample beat, with a random gap first; valid stays up after
    // the beat so that the next one can follow without a gap
    task automatic send_sample(input time_t ts, input price_t pr, input logic last);
        int g;
        g = $urandom_range(0, 99);
        if (g >= 70)
        begin
            smp_ch.valid <= 1'b0;
            repeat (g >= 97 ? $urandom_range(30, 200) : $urandom_range(1, 4)) @(posedge clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.timestamp <= ts;
        smp_ch.price     <= pr;
        smp_ch.last      <= last;
        do
            @(posedge clk);
        while (!smp_ch.ready);
        absorb_sample(ts, pr, last);
        n_items++;
    endtask

    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        // every predicted result has been taken; idle before the next phase
        repeat (400) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_mode = m;
    endtask

    function automatic time_t rand_ts(input int style);
        case (style)
            0: return $urandom_range(0, 3);          // many ties
            1: return $urandom();
            default: return 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    function automatic price_t rand_pr(input int style);
        case (style)
            0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1: return $urandom();
            default: return price_t'(32'sd65536 * $urandom_range(0, 40) - 32'sd1310720);
        endcase
    endfunction

    row_t dir_tab [$];

    function automatic void add_row(input time_t ts, input price_t pr, input logic last,
                                    input logic known, input value_t v, input count_t c,
                                    input logic o, input logic s);
        row_t r;
        r.ts = ts; r.pr = pr; r.last = last; r.known = known;
        r.ans.value = v; r.ans.count = c; r.ans.ovf = o; r.ans.sat = s;
        dir_tab = {dir_tab, r};
    endfunction

    initial
    begin
        int   len, ts_style, pr_style;
        agg_t got_pred;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.mode = '0;
        smp_ch.valid = 1'b0;
        smp_ch.timestamp = '0;
        smp_ch.price = '0;
        smp_ch.last = 1'b0;
        cycles = 0;
        hold_off = 1'b0;
        n_items = 0;
        grp_fill = 0;
        grp_ovf = 1'b0;
        cur_mode = MODE_DRIFT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, drift mode after reset
        add_row(32'h0, 32'sh7FFFFFFF, 1'b1, 1'b1, 64'sd0, 9'd1, 1'b0, 1'b0); // single sample
        add_row(32'h5, 32'sh1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(32'h5, 32'sh9, 1'b1, 1'b1, 64'sd0, 9'd1, 1'b0, 1'b0);       // equal stamps
        add_row(32'hFFFFFFFF, 32'sh80000000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0); // reverse order
        add_row(32'h0, 32'sh7FFFFFFF, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(32'h0, 32'sh80000000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);        // huge step
        add_row(32'h1, 32'sh7FFFFFFF, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(32'h0100_0000, 32'sh0001_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(32'h0100_0000, 32'sh0003_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0); // tie order
        add_row(32'h0200_0000, 32'sh0002_0000, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        foreach (dir_tab[i])
        begin
            send_sample(dir_tab[i].ts, dir_tab[i].pr, dir_tab[i].last);
            if (dir_tab[i].last && dir_tab[i].known)
            begin
                got_pred = pending_q[$];
                if (got_pred.value !== dir_tab[i].ans.value
                    || got_pred.count !== dir_tab[i].ans.count
                    || got_pred.ovf !== dir_tab[i].ans.ovf
                    || got_pred.sat !== dir_tab[i].ans.sat)
                    report("table row", got_pred.value, dir_tab[i].ans.value);
            end
        end
        drain();

        // Remaining modes on the huge-step pair, plus one overfull group
        for (int m = 1; m < 4; m++)
        begin
            write_mode(m[1:0]);
            send_sample(32'h0, 32'sh80000000, 1'b0);
            send_sample(32'h1, 32'sh7FFFFFFF, 1'b0);
            send_sample(32'h1, 32'sh0, 1'b1);
            drain();
        end
        write_mode(MODE_COUNT);
        for (int i = 0; i <= DEPTH_TB + 1; i++)
            send_sample(time_t'(i), price_t'(i), i == DEPTH_TB + 1);
        drain();

        // Random groups; mode changes between phases, mostly short groups
        for (int ph = 0; ph < 8; ph++)
        begin
            write_mode(ph == 0 ? 2'b11 : ph == 1 ? 2'b00 : 2'($urandom()));
            if (ph == 3)
                hold_off = 1'b1;    // receiver stalls while groups pile in
            for (int g = 0; g < 12; g++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
                ts_style = $urandom_range(0, 2);
                pr_style = $urandom_range(0, 2);
                for (int k = 0; k < len; k++)
                    send_sample(rand_ts(ts_style), rand_pr(pr_style), k == len - 1);
                if ($urandom_range(0, 12) == 0)
                    send_sample($urandom(), $urandom(), 1'b1);
            end
            drain();
        end

        $display("%0d samples, %0d results; groups per mode drift %0d var %0d root %0d cnt %0d",
                 n_items, n_results, mode_use[0], mode_use[1], mode_use[2], mode_use[3]);
        $display("covered ties, reversed order, saturation, overfull store, long output stall");
        if (errors == 0 && pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sirs_pkg.sv
sv/sirs_if.sv
sv/sirs_cell.sv
sv/sirs_sqrt.sv
sv/sirs_div.sv
sv/sorted_increment_ratio_sum_unit.sv
sim/tb_sorted_increment_ratio_sum_unit.sv
